[src/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked property, idle while reset is high
`define TPCD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: label");
// checked property, also active during reset
`define TPCD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: label");
`else
`define TPCD_ASSERT(label, clk, rst, prop)
`define TPCD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[src/tpcd_pkg.sv]
`default_nettype none

package tpcd_pkg;

  // number of triac channels
  localparam int TPCD_CHANNELS = 4;
  // channels shown on the status fields
  localparam int VIS_CHANNELS = 4;
  // width that covers both the channels and the status fields
  localparam int WIDE_W = (TPCD_CHANNELS > VIS_CHANNELS) ? TPCD_CHANNELS : VIS_CHANNELS;
  // channel that owns the auxiliary ballast line
  localparam int AUX_CHANNEL = 3;

  localparam logic [9:0] OFF_CODE   = 10'd550;
  localparam logic [9:0] FIRE_BASE  = 10'd512;
  localparam logic [7:0] FULL_LEVEL = 8'd255;

  // register reset values
  localparam logic [9:0] OFF_POINT_RST    = 10'd550;
  localparam logic [9:0] PERIOD_TOP_RST   = 10'd625;
  localparam logic [9:0] RESYNC_VALUE_RST = 10'd620;
  localparam logic [3:0] GAMMA_MASK_RST   = 4'd8;

  typedef enum logic [1:0] {
    REG_OFF_POINT    = 2'd0,
    REG_PERIOD_TOP   = 2'd1,
    REG_RESYNC_VALUE = 2'd2,
    REG_GAMMA_MASK   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_ZERO_CROSS = 2'd1,
    FUNC_SET_LEVEL  = 2'd2,
    FUNC_SET_ENABLE = 2'd3
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [2:0] channel;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] gate_mask;
    logic       aux_on;
    logic [3:0] enabled_mask;
  } out_item_t;

  typedef struct packed {
    logic [9:0] off_point;
    logic [9:0] period_top;
    logic [9:0] resync_value;
    logic [3:0] gamma_mask;
  } cfg_t;

  // gamma correction of the requested level
  localparam logic [7:0] GAMMA_TAB [256] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
    8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253,
    8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253,
    8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd253, 8'd252,
    8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252,
    8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252, 8'd252,
    8'd252, 8'd251, 8'd251, 8'd251, 8'd251, 8'd251, 8'd251, 8'd251,
    8'd251, 8'd251, 8'd251, 8'd251, 8'd251, 8'd250, 8'd250, 8'd250,
    8'd250, 8'd250, 8'd250, 8'd250, 8'd250, 8'd250, 8'd249, 8'd249,
    8'd249, 8'd249, 8'd249, 8'd249, 8'd249, 8'd249, 8'd248, 8'd248,
    8'd248, 8'd248, 8'd248, 8'd248, 8'd247, 8'd247, 8'd247, 8'd247,
    8'd247, 8'd247, 8'd246, 8'd246, 8'd246, 8'd246, 8'd246, 8'd245,
    8'd245, 8'd245, 8'd245, 8'd245, 8'd244, 8'd244, 8'd244, 8'd244,
    8'd243, 8'd243, 8'd243, 8'd243, 8'd242, 8'd242, 8'd242, 8'd241,
    8'd241, 8'd241, 8'd241, 8'd240, 8'd240, 8'd240, 8'd239, 8'd239,
    8'd239, 8'd238, 8'd238, 8'd237, 8'd237, 8'd237, 8'd236, 8'd236,
    8'd235, 8'd235, 8'd234, 8'd234, 8'd234, 8'd233, 8'd233, 8'd232,
    8'd232, 8'd231, 8'd231, 8'd230, 8'd230, 8'd229, 8'd228, 8'd228,
    8'd227, 8'd227, 8'd226, 8'd225, 8'd225, 8'd224, 8'd223, 8'd223,
    8'd222, 8'd221, 8'd220, 8'd220, 8'd219, 8'd218, 8'd217, 8'd216,
    8'd216, 8'd215, 8'd214, 8'd213, 8'd212, 8'd211, 8'd210, 8'd209,
    8'd208, 8'd207, 8'd206, 8'd205, 8'd204, 8'd203, 8'd202, 8'd200,
    8'd199, 8'd198, 8'd197, 8'd196, 8'd194, 8'd193, 8'd192, 8'd190,
    8'd189, 8'd187, 8'd186, 8'd184, 8'd183, 8'd181, 8'd179, 8'd178,
    8'd176, 8'd174, 8'd173, 8'd171, 8'd169, 8'd167, 8'd165, 8'd163,
    8'd161, 8'd159, 8'd157, 8'd155, 8'd153, 8'd150, 8'd148, 8'd146,
    8'd143, 8'd141, 8'd138, 8'd136, 8'd133, 8'd131, 8'd128, 8'd125,
    8'd122, 8'd119, 8'd116, 8'd113, 8'd110, 8'd107, 8'd104, 8'd100,
    8'd97,  8'd93,  8'd90,  8'd86,  8'd83,  8'd79,  8'd75,  8'd71,
    8'd67,  8'd63,  8'd59,  8'd54,  8'd50,  8'd45,  8'd41,  8'd36,
    8'd31,  8'd26,  8'd21,  8'd16,  8'd11,  8'd5,   8'd0,   8'd0
  };

endpackage

`default_nettype wire

[src/tpcd_cfg_regs.sv]
`default_nettype none

module tpcd_cfg_regs (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire tpcd_pkg::reg_index_t cfg_index,
  input  wire logic [9:0]          cfg_data,
  output tpcd_pkg::cfg_t           cfg
);

  tpcd_pkg::cfg_t cfg_reg;

  // register writes, each keeps its own width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.off_point    <= tpcd_pkg::OFF_POINT_RST;
      cfg_reg.period_top   <= tpcd_pkg::PERIOD_TOP_RST;
      cfg_reg.resync_value <= tpcd_pkg::RESYNC_VALUE_RST;
      cfg_reg.gamma_mask   <= tpcd_pkg::GAMMA_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tpcd_pkg::REG_OFF_POINT:    cfg_reg.off_point    <= cfg_data;
        tpcd_pkg::REG_PERIOD_TOP:   cfg_reg.period_top   <= cfg_data;
        tpcd_pkg::REG_RESYNC_VALUE: cfg_reg.resync_value <= cfg_data;
        tpcd_pkg::REG_GAMMA_MASK:   cfg_reg.gamma_mask   <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule

`default_nettype wire

[src/tpcd_channel_core.sv]
`default_nettype none

`include "assert_macros.svh"

module tpcd_channel_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req,
  input  wire tpcd_pkg::in_item_t  item,
  input  wire tpcd_pkg::cfg_t      cfg,
  output tpcd_pkg::out_item_t      result_next
);

  localparam int N = tpcd_pkg::TPCD_CHANNELS;
  localparam int W = tpcd_pkg::WIDE_W;

  logic [9:0]   phase_counter;
  logic [9:0]   pending_fire [N];
  logic [9:0]   working_fire [N];
  logic [N-1:0] full_on;
  logic [N-1:0] chan_enabled;
  logic [N-1:0] gate_reg;
  logic         aux_reg;

  logic [9:0]   phase_counter_next;
  logic [9:0]   pending_fire_next [N];
  logic [9:0]   working_fire_next [N];
  logic [N-1:0] full_on_next;
  logic [N-1:0] chan_enabled_next;
  logic [N-1:0] gate_reg_next;
  logic         aux_reg_next;

  logic [W-1:0] gamma_wide;
  logic [W-1:0] en_wide;
  logic [W-1:0] en_next_wide;
  logic [W-1:0] gate_next_wide;
  logic [W-1:0] gate_wide;

  assign gamma_wide     = W'(cfg.gamma_mask);
  assign en_wide        = W'(chan_enabled);
  assign en_next_wide   = W'(chan_enabled_next);
  assign gate_next_wide = W'(gate_reg_next);
  assign gate_wide      = W'(gate_reg);

  // next state for one request
  always_comb begin
    logic       sel;
    logic [7:0] lvl;
    logic       at_off;
    phase_counter_next = phase_counter;
    full_on_next       = full_on;
    chan_enabled_next  = chan_enabled;
    gate_reg_next      = gate_reg;
    aux_reg_next       = aux_reg;
    for (int c = 0; c < N; c++) begin
      pending_fire_next[c] = pending_fire[c];
      working_fire_next[c] = working_fire[c];
    end
    at_off = 1'b0;
    sel    = 1'b0;
    lvl    = 8'd0;

    case (item.func)
      // advance the phase counter and run the parallel compares
      tpcd_pkg::FUNC_TICK: begin
        if (phase_counter >= cfg.period_top) begin
          phase_counter_next = 10'd0;
        end else begin
          phase_counter_next = phase_counter + 10'd1;
        end
        at_off = (phase_counter_next == cfg.off_point);
        for (int c = 0; c < N; c++) begin
          if (at_off) begin
            if (!full_on[c]) begin
              gate_reg_next[c] = 1'b0;
            end
            working_fire_next[c] = pending_fire[c];
          end
          if (chan_enabled[c] && working_fire_next[c] != tpcd_pkg::OFF_CODE &&
              working_fire_next[c] == phase_counter_next) begin
            gate_reg_next[c] = 1'b1;
          end
        end
      end

      // resync to mains and raise the aux line when its channel is enabled
      tpcd_pkg::FUNC_ZERO_CROSS: begin
        phase_counter_next = cfg.resync_value;
        if (N > tpcd_pkg::AUX_CHANNEL && en_wide[tpcd_pkg::AUX_CHANNEL]) begin
          aux_reg_next = 1'b1;
        end
      end

      // new level, optionally gamma mapped
      tpcd_pkg::FUNC_SET_LEVEL: begin
        for (int c = 0; c < N; c++) begin
          sel = (item.channel == 3'(c));
          lvl = item.value;
          if (c < tpcd_pkg::VIS_CHANNELS && gamma_wide[c]) begin
            lvl = tpcd_pkg::GAMMA_TAB[item.value];
          end
          if (sel) begin
            if (lvl == tpcd_pkg::FULL_LEVEL) begin
              full_on_next[c]      = 1'b1;
              pending_fire_next[c] = tpcd_pkg::OFF_CODE;
              if (chan_enabled[c]) begin
                gate_reg_next[c] = 1'b1;
              end
            end else begin
              full_on_next[c] = 1'b0;
              if (lvl == 8'd0) begin
                pending_fire_next[c] = tpcd_pkg::OFF_CODE;
              end else begin
                pending_fire_next[c] = tpcd_pkg::FIRE_BASE - {1'b0, lvl, 1'b0};
              end
            end
          end
        end
      end

      // channel enable, aux channel keeps its gate but drops the aux line on disable
      tpcd_pkg::FUNC_SET_ENABLE: begin
        for (int c = 0; c < N; c++) begin
          sel = (item.channel == 3'(c));
          if (sel) begin
            chan_enabled_next[c] = (item.value != 8'd0);
            if (item.value != 8'd0) begin
              if (full_on[c]) begin
                gate_reg_next[c] = 1'b1;
              end
            end else if (c == tpcd_pkg::AUX_CHANNEL) begin
              aux_reg_next = 1'b0;
            end else begin
              gate_reg_next[c] = 1'b0;
            end
          end
        end
      end

      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_counter <= 10'd0;
      full_on       <= '0;
      chan_enabled  <= '0;
      gate_reg      <= '0;
      aux_reg       <= 1'b0;
      for (int c = 0; c < N; c++) begin
        pending_fire[c] <= tpcd_pkg::OFF_CODE;
        working_fire[c] <= tpcd_pkg::OFF_CODE;
      end
    end else if (req) begin
      phase_counter <= phase_counter_next;
      full_on       <= full_on_next;
      chan_enabled  <= chan_enabled_next;
      gate_reg      <= gate_reg_next;
      aux_reg       <= aux_reg_next;
      for (int c = 0; c < N; c++) begin
        pending_fire[c] <= pending_fire_next[c];
        working_fire[c] <= working_fire_next[c];
      end
    end
  end

  // status seen after this request
  assign result_next.gate_mask    = gate_next_wide[3:0];
  assign result_next.aux_on       = aux_reg_next;
  assign result_next.enabled_mask = en_next_wide[3:0];

  // a lit gate on a plain channel means it is enabled
  `TPCD_ASSERT(a_gate_needs_enable, clk, rst, (gate_wide[2:0] & ~en_wide[2:0]) == 3'd0)
  // the aux line only stays up while its channel is enabled
  `TPCD_ASSERT(a_aux_needs_enable, clk, rst, aux_reg |-> en_wide[tpcd_pkg::AUX_CHANNEL])

endmodule

`default_nettype wire

[src/triac_phase_cut_dimmer.sv]
`default_nettype none

`include "assert_macros.svh"

// Phase-cut mains dimmer for four triac channels plus an aux ballast line.
// Input channel in_valid/in_ready carries one request: a timer tick, a
// zero-cross, a set-level or a set-enable for one channel. Every request
// yields one result on out_valid/out_ready: gate outputs, aux line and enable
// flags as they stand after that request.
// A request is taken into the result register as it is accepted, so its result
// shows in the cycle after acceptance. Throughput is one request per cycle while
// the receiver takes each result; the channel compares run in parallel and the
// state plus one result register update in a single pass.
// When the receiver stalls, the result waits in the result register and
// in_ready drops until it is taken; in_ready rises again in the cycle where
// out_ready takes the result.
// The register port (cfg_we, cfg_index, cfg_data) writes off_point,
// period_top, resync_value and gamma_mask; write only while idle.
// Synchronous reset loads the register defaults, clears the counter, gates,
// enables and aux line, sets all firing times to the off code and empties
// the result register.
module triac_phase_cut_dimmer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tpcd_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tpcd_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire tpcd_pkg::reg_index_t cfg_index,
  input  wire logic [9:0]           cfg_data
);

  tpcd_pkg::cfg_t      cfg;
  tpcd_pkg::out_item_t result_next;
  logic                req;

  tpcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // take a request when the result slot is free or being emptied
  assign in_ready = !out_valid || out_ready;
  assign req      = in_valid && in_ready;

  tpcd_channel_core u_core (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .item        (in_data),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      out_data <= result_next;
    end
  end

  // an accepted request always leaves a result behind
  `TPCD_ASSERT(a_req_gives_result, clk, rst, req |=> out_valid)

endmodule

`default_nettype wire
